// ----- rtl/core/slcd_pkg.sv -----
// ----------------------------------------------------------------------------
// slcd_pkg
// Shared types, codes and the byte-wide CRC-32 update for the sync-word,
// length-prefixed frame deframer.
// ----------------------------------------------------------------------------
package slcd_pkg;

  // Receive phase, one-hot coded.
  typedef enum logic [3:0] {
    PH_HUNT = 4'b0001,
    PH_CRC  = 4'b0010,
    PH_LEN  = 4'b0100,
    PH_PAY  = 4'b1000
  } slcd_phase_t;

  // Result event codes.
  localparam logic [1:0] EV_PAYLOAD  = 2'd0;
  localparam logic [1:0] EV_CRC_GOOD = 2'd1;
  localparam logic [1:0] EV_CRC_BAD  = 2'd2;
  localparam logic [1:0] EV_OVERSIZE = 2'd3;

  // Register indexes, taken from paddr[2].
  localparam logic REG_SYNC_PATTERN = 1'b0;
  localparam logic REG_MAX_LENGTH   = 1'b1;

  localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
  localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;
  localparam logic [15:0] MAX_LENGTH_RESET = 16'd1024;

  // One result word.
  typedef struct packed {
    logic [15:0] frame_length;
    logic        has_byte;
    logic [7:0]  out_byte;
    logic [1:0]  event_res;
  } slcd_res_t;

  // Reflected CRC-32 update over one byte.
  function automatic logic [31:0] crc_byte(input logic [31:0] crc_in,
                                           input logic [7:0] b);
    logic [31:0] c;
    c = crc_in ^ {24'd0, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

// ----- rtl/core/slcd_out_buf.sv -----
// ----------------------------------------------------------------------------
// slcd_out_buf
// Output register with a skid stage. Upstream ready depends only on the
// skid entry, so the result path is registered on both sides.
// ----------------------------------------------------------------------------
module slcd_out_buf (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  slcd_pkg::slcd_res_t in_res,
  output logic                out_valid,
  input  logic                out_ready,
  output slcd_pkg::slcd_res_t out_res
);
  import slcd_pkg::*;

  logic      sk_valid;
  slcd_res_t sk_res;

  assign in_ready = !sk_valid;

  // Control: the output word drains first, then the skid word moves up.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      sk_valid  <= 1'b0;
    end else if (out_ready || !out_valid) begin
      if (sk_valid) begin
        out_valid <= 1'b1;
        sk_valid  <= 1'b0;
      end else begin
        out_valid <= in_valid;
      end
    end else if (in_valid) begin
      sk_valid <= 1'b1;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (out_ready || !out_valid) begin
      out_res <= sk_valid ? sk_res : in_res;
    end else if (in_valid && !sk_valid) begin
      sk_res <= in_res;
    end
  end

endmodule

// ----- rtl/core/sync_length_crc32_deframer.sv -----
// ----------------------------------------------------------------------------
// sync_length_crc32_deframer
// Hunts for a sync word, reads a CRC and length header, streams the payload
// and reports the CRC check at the frame end.
// ----------------------------------------------------------------------------
// One received byte is taken per clock cycle, every cycle, as long as the
// output side keeps up. Each byte is handled in the cycle it is accepted: the
// phase logic and the byte-wide CRC-32 update sit between the state registers
// and a two-word output buffer, whose registers hold each result on its way
// to the master side. Input ready drops only when both output words are
// held by a stalled downstream. Header and hunting bytes give no word; every
// payload byte gives one, and an oversize or zero-length header gives one.
// ----------------------------------------------------------------------------
module sync_length_crc32_deframer (
  input  logic        clk,
  input  logic        rst,
  // Byte stream in.
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] in_byte
  // Result stream out.
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // [7:0] out_byte, [23:8] frame_length
  output logic [2:0]  m_tuser,   // [1:0] event_res, [2] has_byte
  // Configuration port.
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import slcd_pkg::*;

  logic [31:0] sync_pattern;
  logic [15:0] max_length;

  slcd_phase_t phase, phase_next;
  logic [31:0] sync_shift, sync_shift_next;
  logic [1:0]  header_count, header_count_next;
  logic [31:0] header_shift, header_shift_next;
  logic [31:0] expected_crc, expected_crc_next;
  logic [15:0] payload_length, payload_length_next;
  logic [15:0] payload_count, payload_count_next;
  logic [31:0] running_crc, running_crc_next;

  logic        accept;
  logic        res_valid;
  slcd_res_t   res;
  slcd_res_t   out_res;
  logic [31:0] crc_upd;
  logic [15:0] count_inc;

  // Configuration registers.
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      sync_pattern <= '0;
      max_length   <= MAX_LENGTH_RESET;
    end else if (psel && penable && pwrite && pready) begin
      unique case (paddr[2])
        REG_SYNC_PATTERN: sync_pattern <= pwdata;
        REG_MAX_LENGTH:   max_length   <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_SYNC_PATTERN: prdata = sync_pattern;
      REG_MAX_LENGTH:   prdata = {16'd0, max_length};
      default:          prdata = '0;
    endcase
  end

  assign accept    = s_tvalid && s_tready;
  assign crc_upd   = crc_byte(running_crc, s_tdata);
  assign count_inc = payload_count + 16'd1;

  // Per-byte phase logic.
  always_comb begin
    phase_next          = phase;
    sync_shift_next     = sync_shift;
    header_count_next   = header_count;
    header_shift_next   = header_shift;
    expected_crc_next   = expected_crc;
    payload_length_next = payload_length;
    payload_count_next  = payload_count;
    running_crc_next    = running_crc;
    res_valid           = 1'b0;
    res                 = '0;

    unique case (phase)
      PH_HUNT: begin
        sync_shift_next = {s_tdata, sync_shift[31:8]};
        if (sync_shift_next == sync_pattern) begin
          phase_next        = PH_CRC;
          header_count_next = 2'd0;
        end
      end

      PH_CRC: begin
        header_shift_next = {s_tdata, header_shift[31:8]};
        if (header_count == 2'd3) begin
          expected_crc_next = header_shift_next;
          header_count_next = 2'd0;
          phase_next        = PH_LEN;
        end else begin
          header_count_next = header_count + 2'd1;
        end
      end

      PH_LEN: begin
        header_shift_next = {s_tdata, header_shift[31:8]};
        if (header_count != 2'd3) begin
          header_count_next = header_count + 2'd1;
        end else begin
          header_count_next = 2'd0;
          if (header_shift_next > {16'd0, max_length}) begin
            // Oversize frame: report the saturated length and drop it.
            res_valid          = 1'b1;
            res.event_res      = EV_OVERSIZE;
            res.frame_length   = (|header_shift_next[31:16]) ? 16'hFFFF
                                                             : header_shift_next[15:0];
            phase_next         = PH_HUNT;
            sync_shift_next    = '0;
          end else begin
            payload_length_next = header_shift_next[15:0];
            payload_count_next  = 16'd0;
            running_crc_next    = CRC_INIT;
            if (header_shift_next[15:0] == 16'd0) begin
              // Empty payload: its CRC is zero.
              res_valid       = 1'b1;
              res.event_res   = (expected_crc == 32'd0) ? EV_CRC_GOOD : EV_CRC_BAD;
              phase_next      = PH_HUNT;
              sync_shift_next = '0;
            end else begin
              phase_next = PH_PAY;
            end
          end
        end
      end

      PH_PAY: begin
        running_crc_next   = crc_upd;
        payload_count_next = count_inc;
        res_valid          = 1'b1;
        res.out_byte       = s_tdata;
        res.has_byte       = 1'b1;
        res.frame_length   = payload_length;
        if (count_inc == payload_length) begin
          res.event_res   = ((~crc_upd) == expected_crc) ? EV_CRC_GOOD : EV_CRC_BAD;
          phase_next      = PH_HUNT;
          sync_shift_next = '0;
        end else begin
          res.event_res = EV_PAYLOAD;
        end
      end

      default: begin
        phase_next = PH_HUNT;
      end
    endcase
  end

  // State registers, updated on each accepted byte.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_HUNT;
      sync_shift     <= '0;
      header_count   <= '0;
      header_shift   <= '0;
      expected_crc   <= '0;
      payload_length <= '0;
      payload_count  <= '0;
      running_crc    <= CRC_INIT;
    end else if (accept) begin
      phase          <= phase_next;
      sync_shift     <= sync_shift_next;
      header_count   <= header_count_next;
      header_shift   <= header_shift_next;
      expected_crc   <= expected_crc_next;
      payload_length <= payload_length_next;
      payload_count  <= payload_count_next;
      running_crc    <= running_crc_next;
    end
  end

  // Output buffer.
  slcd_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (accept && res_valid),
    .in_ready  (s_tready),
    .in_res    (res),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_res   (out_res)
  );

  assign m_tdata = {out_res.frame_length, out_res.out_byte};
  assign m_tuser = {out_res.has_byte, out_res.event_res};

  // The payload counter never reaches the frame length inside a frame.
  a_pay_count: assert property (@(posedge clk) disable iff (rst)
    phase == PH_PAY |-> (payload_count < payload_length))
    else $error("payload count reached length inside payload phase");

  // Header byte counter is idle outside the header phases.
  a_hdr_idle: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_HUNT || phase == PH_PAY) |-> header_count == 2'd0)
    else $error("header count not zero outside header phases");

  // A payload phase starts with a fresh CRC and count.
  a_pay_start: assert property (@(posedge clk) disable iff (rst)
    ($past(phase) == PH_LEN && phase == PH_PAY) |->
      (running_crc == CRC_INIT && payload_count == 16'd0 && payload_length != 16'd0))
    else $error("payload phase entered without fresh CRC state");

  // A dropped frame carries no byte.
  a_drop_nobyte: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && out_res.event_res == EV_OVERSIZE) |->
      (!out_res.has_byte && out_res.out_byte == 8'd0))
    else $error("oversize result carries a byte");

endmodule

// ----- verif/tb_sync_length_crc32_deframer.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_sync_length_crc32_deframer
// Self-checking bench for the sync-word, length-prefixed CRC-32 deframer.
// A short table of hand-built frames runs first. Then come randomized frames
// under several sync and length-limit settings, with noise, spoiled CRCs and
// cut-off frames. One frame at the length limit closes the run. An in-bench
// predictor tracks the receive phases and the CRC. Every word from the block
// is compared field by field against the oldest expected word.
// ----------------------------------------------------------------------------
module tb_sync_length_crc32_deframer;
  import slcd_pkg::*;

  localparam logic [31:0] POLY_REFLECTED = 32'hEDB8_8320;

  // How a table row is checked: no word, a hand-typed word, or the predictor.
  typedef enum logic [1:0] {ROW_QUIET, ROW_TYPED, ROW_PRED} row_kind_t;

  typedef struct packed {
    logic [7:0] data;
    row_kind_t  kind;
    slcd_res_t  res;
  } dir_row_t;

  // Directed frames, under the reset settings (sync word 0, limit 1024).
  // The first frame has zero length and a zero CRC. The second has an
  // all-ones length, which is dropped and saturated. The third carries two
  // payload bytes.
  localparam dir_row_t DIR_ROWS [0:28] = '{
    '{8'h00, ROW_QUIET, '0}, '{8'h00, ROW_QUIET, '0}, '{8'h00, ROW_QUIET, '0},
    '{8'h00, ROW_QUIET, '0}, '{8'h00, ROW_QUIET, '0}, '{8'h00, ROW_QUIET, '0},
    '{8'h00, ROW_QUIET, '0}, '{8'h00, ROW_QUIET, '0},
    '{8'h00, ROW_TYPED, '{16'h0000, 1'b0, 8'h00, EV_CRC_GOOD}},
    '{8'h00, ROW_QUIET, '0}, '{8'h12, ROW_QUIET, '0}, '{8'h34, ROW_QUIET, '0},
    '{8'h56, ROW_QUIET, '0}, '{8'h78, ROW_QUIET, '0}, '{8'hFF, ROW_QUIET, '0},
    '{8'hFF, ROW_QUIET, '0}, '{8'hFF, ROW_QUIET, '0},
    '{8'hFF, ROW_TYPED, '{16'hFFFF, 1'b0, 8'h00, EV_OVERSIZE}},
    '{8'h00, ROW_QUIET, '0}, '{8'h00, ROW_QUIET, '0}, '{8'h00, ROW_QUIET, '0},
    '{8'h00, ROW_QUIET, '0}, '{8'hFF, ROW_QUIET, '0}, '{8'h02, ROW_QUIET, '0},
    '{8'h00, ROW_QUIET, '0}, '{8'h00, ROW_QUIET, '0}, '{8'h00, ROW_QUIET, '0},
    '{8'h00, ROW_PRED, '0}, '{8'hFF, ROW_PRED, '0}
  };

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [7:0]  s_tdata;   // [7:0] in_byte
  logic        m_tvalid;
  logic        m_tready;
  logic [23:0] m_tdata;   // [7:0] out_byte, [23:8] frame_length
  logic [2:0]  m_tuser;   // [1:0] event_res, [2] has_byte
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  // Predictor copy of the settings and of the receive state.
  logic [31:0] cfg_sync;
  logic [15:0] cfg_max;
  slcd_phase_t fr_phase;
  logic [31:0] hunt_shift;
  logic [1:0]  hdr_cnt;
  logic [31:0] hdr_shift;
  logic [31:0] want_crc;
  logic [15:0] pay_len;
  logic [15:0] pay_cnt;
  logic [31:0] crc_acc;

  slcd_res_t   pending_words[$];
  slcd_res_t   due_word;
  int          err_count;
  int          bytes_sent;
  bit          gaps_on;
  int          rx_hold_len;

  sync_length_crc32_deframer dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  // Reflected CRC-32, fed one data bit at a time, least significant first.
  function automatic logic [31:0] crc32_update(input logic [31:0] c,
                                               input logic [7:0] d);
    for (int k = 0; k < 8; k++) begin
      c = (c[0] ^ d[k]) ? ((c >> 1) ^ POLY_REFLECTED) : (c >> 1);
    end
    return c;
  endfunction

  function automatic void back_to_hunt();
    fr_phase   = PH_HUNT;
    hunt_shift = '0;
    hdr_cnt    = '0;
  endfunction

  // Advances the deframer prediction by one byte. Returns 1 when a word is due.
  function automatic bit deframe_byte(input logic [7:0] b, output slcd_res_t r);
    r = '0;
    case (fr_phase)
      PH_HUNT: begin
        hunt_shift = {b, hunt_shift[31:8]};
        if (hunt_shift == cfg_sync) begin
          fr_phase = PH_CRC;
          hdr_cnt  = '0;
        end
        return 1'b0;
      end
      PH_CRC: begin
        hdr_shift = {b, hdr_shift[31:8]};
        if (hdr_cnt == 2'd3) begin
          want_crc = hdr_shift;
          hdr_cnt  = '0;
          fr_phase = PH_LEN;
        end else begin
          hdr_cnt = hdr_cnt + 2'd1;
        end
        return 1'b0;
      end
      PH_LEN: begin
        hdr_shift = {b, hdr_shift[31:8]};
        if (hdr_cnt != 2'd3) begin
          hdr_cnt = hdr_cnt + 2'd1;
          return 1'b0;
        end
        hdr_cnt = '0;
        // A length over the limit drops the frame; the reported length saturates.
        if (hdr_shift > {16'd0, cfg_max}) begin
          r.event_res    = EV_OVERSIZE;
          r.frame_length = (hdr_shift > 32'h0000_FFFF) ? 16'hFFFF : hdr_shift[15:0];
          back_to_hunt();
          return 1'b1;
        end
        pay_len = hdr_shift[15:0];
        pay_cnt = '0;
        crc_acc = '1;
        // An empty payload ends the frame on the last length byte.
        if (pay_len == 16'd0) begin
          r.event_res = (want_crc == 32'd0) ? EV_CRC_GOOD : EV_CRC_BAD;
          back_to_hunt();
          return 1'b1;
        end
        fr_phase = PH_PAY;
        return 1'b0;
      end
      default: begin
        crc_acc        = crc32_update(crc_acc, b);
        pay_cnt        = pay_cnt + 16'd1;
        r.out_byte     = b;
        r.has_byte     = 1'b1;
        r.frame_length = pay_len;
        if (pay_cnt == pay_len) begin
          r.event_res = (~crc_acc == want_crc) ? EV_CRC_GOOD : EV_CRC_BAD;
          back_to_hunt();
        end else begin
          r.event_res = EV_PAYLOAD;
        end
        return 1'b1;
      end
    endcase
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want_val);
    $display("ERROR %s: got 0x%0h, expected 0x%0h at %0t", what, got, want_val, $time);
    err_count++;
  endtask

  // Offers one byte, waits for the handshake and books the predicted word.
  task automatic send_byte(input logic [7:0] b, input row_kind_t kind,
                           input slcd_res_t typed);
    slcd_res_t r;
    bit        hit;
    if (gaps_on && $urandom_range(0, 5) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    hit = deframe_byte(b, r);
    if (kind == ROW_PRED && hit) begin
      pending_words.push_back(r);
    end else if (kind == ROW_TYPED) begin
      pending_words.push_back(typed);
    end
    bytes_sent++;
  endtask

  // Builds a frame under the current settings and sends all of it, or a
  // leading part of it when cut is set.
  task automatic send_frame(input logic [31:0] len32, input bit spoil_crc,
                            input bit cut);
    logic [7:0]  seq[$];
    logic [7:0]  pay[$];
    logic [31:0] crc;
    int          n;
    crc = '1;
    if (len32 <= {16'd0, cfg_max}) begin
      for (int k = 0; k < len32; k++) begin
        pay.push_back(8'($urandom));
        crc = crc32_update(crc, pay[k]);
      end
    end
    crc = ~crc;
    if (spoil_crc) crc ^= 32'd1 << $urandom_range(0, 31);
    // Line noise ahead of the sync word, now and then.
    if ($urandom_range(0, 4) == 0) begin
      repeat ($urandom_range(1, 3)) seq.push_back(8'($urandom));
    end
    for (int k = 0; k < 4; k++) seq.push_back(cfg_sync[8*k +: 8]);
    for (int k = 0; k < 4; k++) seq.push_back(crc[8*k +: 8]);
    for (int k = 0; k < 4; k++) seq.push_back(len32[8*k +: 8]);
    foreach (pay[k]) seq.push_back(pay[k]);
    n = cut ? $urandom_range(1, seq.size() - 1) : seq.size();
    for (int k = 0; k < n; k++) send_byte(seq[k], ROW_PRED, '0);
  endtask

  // APB write: setup cycle, then access cycle, then the bus goes idle.
  task automatic reg_write(input logic reg_idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {reg_idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (reg_idx == REG_SYNC_PATTERN) cfg_sync = value;
    else cfg_max = value[15:0];
    @(posedge clk);
  endtask

  // Stops offering bytes and waits until every booked word has come out.
  task automatic drain_results();
    s_tvalid <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Receiver: random stall bursts, plus one long hold-off on request.
  initial begin
    int n;
    m_tready = 1'b0;
    while (rst) @(posedge clk);
    forever begin
      @(posedge clk);
      if (rx_hold_len > 0) begin
        n = rx_hold_len;
        rx_hold_len = 0;
        m_tready <= 1'b0;
        repeat (n) @(posedge clk);
        m_tready <= 1'b1;
      end else if (gaps_on && $urandom_range(0, 7) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 17)) @(posedge clk);
        m_tready <= 1'b1;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // Compare each accepted word with the oldest expected one.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (pending_words.size() == 0) begin
        report_mismatch("word with nothing expected", {8'd0, m_tdata}, 32'd0);
      end else begin
        due_word = pending_words.pop_front();
        if (m_tuser[1:0] != due_word.event_res)
          report_mismatch("event_res", 32'(m_tuser[1:0]), 32'(due_word.event_res));
        if (m_tdata[7:0] != due_word.out_byte)
          report_mismatch("out_byte", 32'(m_tdata[7:0]), 32'(due_word.out_byte));
        if (m_tuser[2] != due_word.has_byte)
          report_mismatch("has_byte", 32'(m_tuser[2]), 32'(due_word.has_byte));
        if (m_tdata[23:8] != due_word.frame_length)
          report_mismatch("frame_length", 32'(m_tdata[23:8]),
                          32'(due_word.frame_length));
      end
    end
  end

  // Stimulus and final verdict.
  initial begin
    int          base;
    int          lim;
    int          pick;
    logic [31:0] len32;
    logic [31:0] sync_val;
    logic [15:0] max_val;
    bit          allow_cut;

    rst         = 1'b1;
    s_tvalid    = 1'b0;
    s_tdata     = '0;
    psel        = 1'b0;
    penable     = 1'b0;
    pwrite      = 1'b0;
    paddr       = '0;
    pwdata      = '0;
    err_count   = 0;
    bytes_sent  = 0;
    gaps_on     = 1'b1;
    rx_hold_len = 0;
    cfg_sync    = '0;
    cfg_max     = MAX_LENGTH_RESET;
    hdr_shift   = '0;
    want_crc    = '0;
    pay_len     = '0;
    pay_cnt     = '0;
    crc_acc     = '1;
    back_to_hunt();

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (DIR_ROWS[i]) send_byte(DIR_ROWS[i].data, DIR_ROWS[i].kind, DIR_ROWS[i].res);
    drain_results();

    // Randomized frames, one settings pair per pass.
    base = bytes_sent;
    for (int ph = 0; ph < 8; ph++) begin
      drain_results();
      case (ph)
        0: begin sync_val = 32'hFFFF_FFFF; max_val = 16'd0; end
        1: begin sync_val = $urandom; max_val = 16'hFFFF; end
        2: begin sync_val = 32'h0000_0000; max_val = 16'd16; end
        4: begin sync_val = $urandom; max_val = MAX_LENGTH_RESET; end
        default: begin sync_val = $urandom; max_val = 16'($urandom_range(12, 40)); end
      endcase
      reg_write(REG_SYNC_PATTERN, sync_val);
      reg_write(REG_MAX_LENGTH, {16'd0, max_val});
      gaps_on   = (ph < 6);
      allow_cut = (cfg_max <= 16'd40);
      // Long receiver hold-off while frames keep coming in.
      if (ph == 3) rx_hold_len = 150;
      while (bytes_sent < base + 45 * (ph + 1)) begin
        lim  = (cfg_max < 16'd12) ? cfg_max : 12;
        pick = $urandom_range(0, 9);
        if (pick == 0) begin
          len32 = 32'd0;
        end else if (pick == 1) begin
          if (cfg_max != 16'hFFFF && $urandom_range(0, 1) == 1) len32 = cfg_max + 32'd1;
          else len32 = $urandom | 32'h0001_0000;
        end else if (pick == 2 && cfg_max <= 16'd40) begin
          len32 = {16'd0, cfg_max};
        end else begin
          len32 = (lim == 0) ? 32'd0 : $urandom_range(1, lim);
        end
        send_frame(len32, $urandom_range(0, 3) == 0,
                   allow_cut && $urandom_range(0, 11) == 0);
      end
    end

    // Bring the block back to hunting, then send one frame as long as the
    // limit allows.
    while (fr_phase != PH_HUNT) send_byte(8'hFF, ROW_PRED, '0);
    drain_results();
    reg_write(REG_SYNC_PATTERN, $urandom);
    reg_write(REG_MAX_LENGTH, 32'd40);
    send_frame(32'd40, 1'b0, 1'b0);

    drain_results();
    repeat (6) @(posedge clk);
    if (err_count == 0 && pending_words.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #2_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule
